// File: rtl/core/rhbm_pkg.sv
`timescale 1ns / 1ps
package rhbm_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NOT_FOUND   = 3'd0,
    ST_FOUND       = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_DELETED     = 3'd4,
    ST_DEL_MISSING = 3'd5,
    ST_PROBE_LIMIT = 3'd6
  } status_e;

  localparam int unsigned HashW = 32;
  localparam int unsigned BufW  = 10;
  localparam int unsigned DistW = 8;
  localparam int unsigned TagW  = 130;
  localparam int unsigned IdxCfgW = 4;

endpackage

// File: rtl/core/robin_hood_buffer_map_core.sv
`timescale 1ns / 1ps
// Channel   | direction | handshake           | payload
// request   | in        | in_valid_i/in_stall_o   | command_i .. block_number_i
// result    | out       | out_valid_o/out_stall_i | status_o, result_buffer_id_o
// config    | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (index_bits)
// After reset a clearing pass walks every slot of the slot store before any
// request is taken. Each probe passes S_READ, S_TAG, S_WRITE and S_DECIDE: it
// reads the slot memory, then the tag store, then decides, all through one
// shared compare path. Lookup and delete take up to MAX_PROBE+2 passes,
// the last one only noticing the probe limit; insert chains can take more.
// The result register holds while out_stall_i is high; the next request is
// taken only when the sequencer is idle and no result waits under a stall.
module robin_hood_buffer_map_core
  import rhbm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT   = 2048,
  parameter int unsigned BUFFER_COUNT = 1024,
  parameter int unsigned MAX_PROBE    = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [HashW-1:0]     hash_code_i,
  input  logic [BufW-1:0]      buffer_id_i,
  input  logic [31:0]          tablespace_id_i,
  input  logic [31:0]          database_id_i,
  input  logic [31:0]          relation_id_i,
  input  logic [1:0]           fork_number_i,
  input  logic [31:0]          block_number_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [BufW-1:0]      result_buffer_id_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IdxCfgW-1:0]   cfg_data_i
);

  localparam int unsigned SlotAw = $clog2(SLOT_COUNT);
  localparam int unsigned BufAw  = $clog2(BUFFER_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_TAG, S_DECIDE, S_WRITE, S_DONE
  } state_e;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [BufW-1:0]  buf_id;
    logic [DistW-1:0] probe_len;
    logic             occ;
    logic             tomb;
  } slot_t;

  slot_t            slot_mem [SLOT_COUNT];
  logic [TagW-1:0]  tag_mem  [BUFFER_COUNT];

  state_e               state_q;
  logic [SlotAw:0]      clr_q;
  logic [IdxCfgW-1:0]   ibits_q;
  logic [SlotAw-1:0]    mask_q, idx_q;
  logic [1:0]           cmd_q;
  logic [HashW-1:0]     chash_q;
  logic [BufW-1:0]      bid_q, cid_q;
  logic [TagW-1:0]      tag_q;
  logic [DistW:0]       dist_q;
  logic                 disp_q;
  slot_t                rd_q;
  logic [TagW-1:0]      tag_rd_q;
  logic                 out_valid_q;
  logic [2:0]           status_q;
  logic [BufW-1:0]      res_q;
  logic                 wr_en;
  slot_t                wr_data;
  logic                 tag_wr;
  logic [SlotAw-1:0]    wr_addr;

  logic [SlotAw:0] mask_full;
  assign mask_full = (({{SlotAw{1'b0}}, 1'b1} << ibits_q) - 1'b1);

  // Shared compare unit for the probe step.
  logic hit, shorter, limit;
  assign hit     = rd_q.occ && (rd_q.hash == chash_q) && (tag_rd_q == tag_q);
  assign shorter = {1'b0, rd_q.probe_len} < dist_q;
  assign limit   = dist_q > (DistW+1)'(MAX_PROBE);

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign result_buffer_id_o = res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (tag_wr) tag_mem[bid_q[BufAw-1:0]] <= tag_q;
    rd_q     <= slot_mem[idx_q];
    tag_rd_q <= tag_mem[rd_q.buf_id[BufAw-1:0]];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_q;
    tag_wr  = 1'b0;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[SlotAw-1:0];
      wr_data = '0;
    end else if (state_q == S_DECIDE && !limit) begin
      if (cmd_q == CMD_INSERT) begin
        if (!rd_q.occ) begin
          wr_en   = 1'b1;
          wr_data = '{hash: chash_q, buf_id: cid_q, probe_len: dist_q[DistW-1:0],
                      occ: 1'b1, tomb: 1'b0};
          tag_wr  = 1'b1;
        end else if (!(hit && !disp_q) && shorter) begin
          wr_en   = 1'b1;
          wr_data = '{hash: chash_q, buf_id: cid_q, probe_len: dist_q[DistW-1:0],
                      occ: 1'b1, tomb: 1'b0};
        end
      end else if (cmd_q == CMD_DELETE && rd_q.occ && !shorter && hit) begin
        wr_en = 1'b1;
        wr_data.occ  = 1'b0;
        wr_data.tomb = 1'b1;
      end
    end else if (state_q == S_DECIDE && limit && cmd_q == CMD_INSERT && disp_q) begin
      tag_wr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ibits_q     <= IdxCfgW'(11);
      out_valid_q <= 1'b0;
      status_q    <= ST_NOT_FOUND;
      res_q       <= '0;
      mask_q      <= '0;
      idx_q       <= '0;
      cmd_q       <= '0;
      dist_q      <= '0;
      disp_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (SlotAw+1)'(SLOT_COUNT - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid_i) ibits_q <= cfg_data_i;
          if (in_valid_i && !in_stall_o) begin
            cmd_q   <= command_i;
            chash_q <= hash_code_i;
            bid_q   <= buffer_id_i;
            cid_q   <= buffer_id_i;
            tag_q   <= {tablespace_id_i, database_id_i, relation_id_i,
                        block_number_i, fork_number_i};
            mask_q  <= mask_full[SlotAw-1:0];
            idx_q   <= hash_code_i[SlotAw-1:0] & mask_full[SlotAw-1:0];
            dist_q  <= '0;
            disp_q  <= 1'b0;
            if (command_i == CMD_NOP) begin
              status_q <= ST_NOT_FOUND;
              res_q    <= '0;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ:  state_q <= S_TAG;
        S_TAG:   state_q <= S_WRITE;
        S_WRITE: state_q <= S_DECIDE;
        S_DECIDE: begin
          res_q   <= '0;
          state_q <= S_READ;
          idx_q   <= (idx_q + 1'b1) & mask_q;
          dist_q  <= dist_q + 1'b1;
          if (cmd_q == CMD_INSERT) begin
            if (limit) begin
              status_q <= ST_PROBE_LIMIT;
              state_q  <= S_DONE;
            end else if (!rd_q.occ) begin
              status_q <= ST_INSERTED;
              state_q  <= S_DONE;
            end else if (!disp_q && hit) begin
              status_q <= ST_DUPLICATE;
              res_q    <= rd_q.buf_id;
              state_q  <= S_DONE;
            end else if (shorter) begin
              chash_q <= rd_q.hash;
              cid_q   <= rd_q.buf_id;
              dist_q  <= {1'b0, rd_q.probe_len} + 1'b1;
              disp_q  <= 1'b1;
            end
          end else begin
            priority if (limit || (!rd_q.occ && !rd_q.tomb) || (rd_q.occ && shorter)) begin
              status_q <= (cmd_q == CMD_LOOKUP) ? ST_NOT_FOUND : ST_DEL_MISSING;
              state_q  <= S_DONE;
            end else if (hit) begin
              status_q <= (cmd_q == CMD_LOOKUP) ? ST_FOUND : ST_DELETED;
              res_q    <= (cmd_q == CMD_LOOKUP) ? rd_q.buf_id : '0;
              state_q  <= S_DONE;
            end else begin
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("request taken while busy");
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_FOUND && status_o != ST_DUPLICATE)
      |-> (result_buffer_id_o == '0)) else $error("stray buffer id");
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (dist_q <= (DistW+1)'(MAX_PROBE + 1)))
    else $error("probe distance out of range");
endmodule
